FILE: rtl/acep_pkg.sv
// Shared constants and types for the ANSI CSI escape parser.
// Used by the front, back, top level and checker modules and the testbench; depends on nothing.
package acep_pkg;

   // Result status codes.
   localparam logic [2:0] STATUS_TEXT       = 3'd0;
   localparam logic [2:0] STATUS_ABSORBED   = 3'd1;
   localparam logic [2:0] STATUS_DONE       = 3'd2;
   localparam logic [2:0] STATUS_ABORT_TEXT = 3'd3;
   localparam logic [2:0] STATUS_ABORT_ESC  = 3'd4;

   // Byte codes recognized by the parser.
   localparam logic [7:0] CHAR_ESC     = 8'h1B;
   localparam logic [7:0] CHAR_BRACKET = 8'h5B;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UP_A    = 8'h41;
   localparam logic [7:0] CHAR_UP_B    = 8'h42;
   localparam logic [7:0] CHAR_UP_C    = 8'h43;
   localparam logic [7:0] CHAR_UP_D    = 8'h44;
   localparam logic [7:0] CHAR_UP_H    = 8'h48;
   localparam logic [7:0] CHAR_UP_K    = 8'h4B;
   localparam logic [7:0] CHAR_LO_F    = 8'h66;
   localparam logic [7:0] CHAR_LO_H    = 8'h68;
   localparam logic [7:0] CHAR_LO_J    = 8'h6A;
   localparam logic [7:0] CHAR_LO_L    = 8'h6C;
   localparam logic [7:0] CHAR_LO_M    = 8'h6D;
   localparam logic [7:0] CHAR_LO_S    = 8'h73;
   localparam logic [7:0] CHAR_LO_U    = 8'h75;

   // Entries held between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Fixed part of one queued command; parameters and count travel beside it.
   typedef struct packed {
      logic [2:0] status;
      logic [7:0] text_byte;
      logic [7:0] command_byte;
      logic       private_mode;
   } acep_head_type;

endpackage

FILE: rtl/acep_front.sv
// Front end of the escape parser: accepts bytes, runs the sequence state machine
// and the parameter store, and queues one command per byte. Uses acep_pkg.
module acep_front
   import acep_pkg::*;
#(
   parameter int MAX_PARAMS = 8,
   parameter int PARAM_BITS = 16,
   localparam int CW = $clog2(MAX_PARAMS + 1),
   localparam int IW = $clog2(MAX_PARAMS)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,
   input  logic                             queue_full,
   output logic                             push,
   output acep_head_type                    head,
   output logic [CW-1:0]                    count,
   output logic [MAX_PARAMS*PARAM_BITS-1:0] params
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_ESC     = 3'd1;
   localparam logic [2:0] ST_BRACKET = 3'd2;
   localparam logic [2:0] ST_VAL     = 3'd3;
   localparam logic [2:0] ST_SEMI    = 3'd4;
   localparam logic [2:0] ST_EQU     = 3'd5;

   localparam logic [1:0] CTX_BRACKET = 2'd0;
   localparam logic [1:0] CTX_EQU     = 2'd1;
   localparam logic [1:0] CTX_SEMI    = 2'd2;

   logic [2:0]            state_ff;
   logic [1:0]            ctx_ff;
   logic [3:0]            semi_ff;
   logic [CW-1:0]         stored_ff;
   logic                  priv_ff;
   logic                  in_num_ff;
   logic [PARAM_BITS-1:0] store_ff [MAX_PARAMS];

   logic [7:0]            b;
   logic                  is_digit;
   logic                  do_start, do_add, do_semi, do_fin, do_idle, aborted;
   logic                  to_bracket, to_equ, idle_path, has_room;
   logic [1:0]            start_ctx;
   logic [CW-1:0]         last_pos;
   logic [PARAM_BITS+3:0] ext, sum;
   logic [PARAM_BITS-1:0] add_val;

   assign b          = req_tdata;
   assign is_digit   = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;
   assign has_room   = stored_ff < CW'(MAX_PARAMS);
   assign last_pos   = stored_ff - CW'(1);

   always_comb begin
      do_start   = 1'b0;
      do_add     = 1'b0;
      do_semi    = 1'b0;
      do_fin     = 1'b0;
      do_idle    = 1'b0;
      aborted    = 1'b0;
      to_bracket = 1'b0;
      to_equ     = 1'b0;
      start_ctx  = CTX_BRACKET;
      unique case (state_ff)
         ST_ESC: begin
            if (b == CHAR_BRACKET) to_bracket = 1'b1;
            else aborted = 1'b1;
         end
         ST_BRACKET: begin
            if (is_digit) begin
               do_start = 1'b1;
            end else if (b == CHAR_EQUALS) begin
               to_equ = 1'b1;
            end else if (b == CHAR_UP_H || b == CHAR_LO_F || b == CHAR_LO_M ||
                         b == CHAR_LO_S || b == CHAR_LO_U || b == CHAR_UP_K ||
                         b == CHAR_UP_A || b == CHAR_UP_B || b == CHAR_UP_C ||
                         b == CHAR_UP_D) begin
               do_fin = 1'b1;
            end else begin
               aborted = 1'b1;
            end
         end
         ST_EQU: begin
            if (is_digit) begin
               do_start  = 1'b1;
               start_ctx = CTX_EQU;
            end else if (b == CHAR_LO_H || b == CHAR_LO_L) begin
               do_fin = 1'b1;
            end else begin
               aborted = 1'b1;
            end
         end
         ST_SEMI: begin
            if (is_digit) begin
               do_start  = 1'b1;
               start_ctx = CTX_SEMI;
            end else if (b == CHAR_SEMI) begin
               do_semi = 1'b1;
            end else if (b == CHAR_LO_M || b == CHAR_UP_H || b == CHAR_LO_F) begin
               do_fin = 1'b1;
            end else begin
               aborted = 1'b1;
            end
         end
         ST_VAL: begin
            if (is_digit) begin
               do_add = 1'b1;
            end else begin
               unique case (ctx_ff)
                  CTX_BRACKET: begin
                     if (b == CHAR_SEMI) do_semi = 1'b1;
                     else if (b == CHAR_UP_A || b == CHAR_UP_B || b == CHAR_UP_C ||
                              b == CHAR_UP_D || b == CHAR_LO_J || b == CHAR_LO_M)
                        do_fin = 1'b1;
                     else aborted = 1'b1;
                  end
                  CTX_EQU: begin
                     if (b == CHAR_LO_H || b == CHAR_LO_L) do_fin = 1'b1;
                     else aborted = 1'b1;
                  end
                  CTX_SEMI: begin
                     // Cursor position takes two numbers, so H and f only fit
                     // after exactly one semicolon.
                     if (semi_ff == 4'd1 && (b == CHAR_UP_H || b == CHAR_LO_F))
                        do_fin = 1'b1;
                     else if (b == CHAR_SEMI) do_semi = 1'b1;
                     else if (b == CHAR_LO_M) do_fin = 1'b1;
                     else aborted = 1'b1;
                  end
                  default: aborted = 1'b1;
               endcase
            end
         end
         default: do_idle = 1'b1;
      endcase
   end

   assign idle_path = do_idle || aborted;

   always_comb begin
      head.status = STATUS_ABSORBED;
      if (do_fin) begin
         head.status = STATUS_DONE;
      end else if (idle_path) begin
         if (b == CHAR_ESC) head.status = aborted ? STATUS_ABORT_ESC : STATUS_ABSORBED;
         else head.status = aborted ? STATUS_ABORT_TEXT : STATUS_TEXT;
      end
      head.text_byte    = (idle_path && b != CHAR_ESC) ? b : 8'd0;
      head.command_byte = do_fin ? b : 8'd0;
      head.private_mode = do_fin && priv_ff;
      count             = do_fin ? stored_ff : '0;
   end

   for (genvar i = 0; i < MAX_PARAMS; i++) begin : g_params
      assign params[i*PARAM_BITS +: PARAM_BITS] = store_ff[i];
   end

   // Next value of the open parameter: times ten plus the digit, saturated.
   always_comb begin
      ext = {4'd0, store_ff[last_pos[IW-1:0]]};
      sum = (ext << 3) + (ext << 1) + (PARAM_BITS + 4)'(b[3:0]);
      if (sum > {4'd0, {PARAM_BITS{1'b1}}}) add_val = {PARAM_BITS{1'b1}};
      else add_val = sum[PARAM_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ctx_ff    <= CTX_BRACKET;
         semi_ff   <= 4'd0;
         stored_ff <= '0;
         priv_ff   <= 1'b0;
         in_num_ff <= 1'b0;
      end else if (push) begin
         if (do_fin || idle_path) begin
            state_ff  <= (idle_path && b == CHAR_ESC) ? ST_ESC : ST_IDLE;
            ctx_ff    <= CTX_BRACKET;
            semi_ff   <= 4'd0;
            stored_ff <= '0;
            priv_ff   <= 1'b0;
            in_num_ff <= 1'b0;
         end
         if (to_bracket) state_ff <= ST_BRACKET;
         if (to_equ) begin
            state_ff <= ST_EQU;
            priv_ff  <= 1'b1;
         end
         if (do_start) begin
            state_ff  <= ST_VAL;
            ctx_ff    <= start_ctx;
            in_num_ff <= has_room;
            if (has_room) stored_ff <= stored_ff + CW'(1);
         end
         if (do_semi) begin
            state_ff  <= ST_SEMI;
            in_num_ff <= 1'b0;
            if (semi_ff < 4'd15) semi_ff <= semi_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push && do_start && has_room) begin
         store_ff[stored_ff[IW-1:0]] <= PARAM_BITS'(b[3:0]);
      end else if (push && do_add && in_num_ff && stored_ff != '0) begin
         store_ff[last_pos[IW-1:0]] <= add_val;
      end
   end

endmodule

FILE: rtl/acep_queue.sv
// Small first-in first-out queue of parser commands between front and back.
// Generic in width and depth; no package dependency.
module acep_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW = $clog2(DEPTH),
   localparam int NW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             not_empty
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]    fill_ff;

   assign full      = fill_ff == NW'(DEPTH);
   assign not_empty = fill_ff != '0;
   assign rd_data   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         if (pop) rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         if (push && !pop) fill_ff <= fill_ff + NW'(1);
         else if (pop && !push) fill_ff <= fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

FILE: rtl/acep_back.sv
// Back end of the escape parser: takes queued commands and sends one result
// word per stored parameter (or one word) on the result stream. Uses acep_pkg.
module acep_back
   import acep_pkg::*;
#(
   parameter int MAX_PARAMS = 8,
   parameter int PARAM_BITS = 16,
   parameter int DW = 40,
   localparam int CW = $clog2(MAX_PARAMS + 1),
   localparam int IW = $clog2(MAX_PARAMS)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  acep_head_type                    q_head,
   input  logic [CW-1:0]                    q_count,
   input  logic [MAX_PARAMS*PARAM_BITS-1:0] q_params,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [DW-1:0]                    rsp_tdata,
   output logic [2:0]                       rsp_tuser,
   output logic                             rsp_tlast
);

   logic                             cur_valid_ff;
   acep_head_type                    cur_head_ff;
   logic [CW-1:0]                    cur_count_ff;
   logic [MAX_PARAMS*PARAM_BITS-1:0] cur_params_ff;
   logic [IW-1:0]                    k_ff;

   logic                  hs, last, load;
   logic [PARAM_BITS-1:0] value;

   assign rsp_tvalid = cur_valid_ff;
   assign hs         = rsp_tvalid && rsp_tready;
   assign last       = (cur_count_ff == '0) || (CW'(k_ff) == cur_count_ff - CW'(1));
   assign load       = q_valid && (!cur_valid_ff || (hs && last));
   assign pop        = load;
   assign value      = (cur_count_ff == '0) ? '0 : cur_params_ff[k_ff*PARAM_BITS +: PARAM_BITS];

   always_comb begin
      rsp_tdata                           = '0;
      rsp_tdata[7:0]                      = cur_head_ff.text_byte;
      rsp_tdata[15:8]                     = cur_head_ff.command_byte;
      rsp_tdata[16]                       = cur_head_ff.private_mode;
      rsp_tdata[19:17]                    = 3'(k_ff);
      rsp_tdata[20 +: PARAM_BITS]         = value;
      rsp_tdata[20 + PARAM_BITS +: 4]     = 4'(cur_count_ff);
   end
   assign rsp_tuser = cur_head_ff.status;
   assign rsp_tlast = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else if (load) begin
         cur_valid_ff <= 1'b1;
         k_ff         <= '0;
      end else if (hs && last) begin
         cur_valid_ff <= 1'b0;
      end else if (hs) begin
         k_ff <= k_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_head_ff   <= q_head;
         cur_count_ff  <= q_count;
         cur_params_ff <= q_params;
      end
   end

endmodule

FILE: rtl/ansi_csi_escape_parser.sv
// ANSI CSI escape parser, top level. A byte is taken every cycle while the command
// queue has room; its command is then queued, and the back loads its first result word
// into the output register once that is free. A byte that completes a sequence gives
// one word per stored parameter, or one word if none is stored; every other byte gives one.
// Synchronous active-high reset clears the parser state, the queue and the output.
// Depends on acep_pkg, acep_front, acep_queue and acep_back.
module ansi_csi_escape_parser
   import acep_pkg::*;
#(
   parameter int MAX_PARAMS = 8,
   parameter int PARAM_BITS = 16,
   localparam int CW = $clog2(MAX_PARAMS + 1),
   localparam int DW = ((24 + PARAM_BITS + 7) / 8) * 8,
   localparam int QW = $bits(acep_head_type) + CW + MAX_PARAMS * PARAM_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // byte_in
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // text_byte[7:0], command_byte[15:8], private_mode[16], param_index[19:17],
   // param_value[20 +: PARAM_BITS], param_count[next 4 bits], zero fill
   output logic [DW-1:0] rsp_tdata,
   output logic [2:0]    rsp_tuser,   // status
   output logic          rsp_tlast    // last
);

   logic                             full, push, pop, not_empty;
   acep_head_type                    f_head, q_head;
   logic [CW-1:0]                    f_count, q_count;
   logic [MAX_PARAMS*PARAM_BITS-1:0] f_params, q_params;
   logic [QW-1:0]                    q_rd;

   acep_front #(.MAX_PARAMS(MAX_PARAMS), .PARAM_BITS(PARAM_BITS)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .queue_full(full), .push, .head(f_head), .count(f_count), .params(f_params)
   );

   acep_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .push, .wr_data({f_params, f_count, f_head}), .full,
      .pop, .rd_data(q_rd), .not_empty
   );

   assign {q_params, q_count, q_head} = q_rd;

   acep_back #(.MAX_PARAMS(MAX_PARAMS), .PARAM_BITS(PARAM_BITS), .DW(DW)) u_back (
      .clock, .reset, .q_valid(not_empty), .q_head, .q_count, .q_params, .pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

endmodule

FILE: rtl/acep_checker.sv
// Port-level checks for the ANSI CSI escape parser, bound to its top level.
// Uses acep_pkg for the status codes.
module acep_checker
   import acep_pkg::*;
#(
   parameter int MAX_PARAMS = 8,
   parameter int PARAM_BITS = 16,
   localparam int DW = ((24 + PARAM_BITS + 7) / 8) * 8
) (
   input logic          clock,
   input logic          reset,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [DW-1:0] rsp_tdata,
   input logic [2:0]    rsp_tuser,
   input logic          rsp_tlast
);

   logic [2:0] idx;
   logic [3:0] cnt;

   assign idx = rsp_tdata[19:17];
   assign cnt = rsp_tdata[20 + PARAM_BITS +: 4];

   // Reset empties the queue and the output register.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("outputs not cleared by reset");

   // Only a completed sequence spreads over several words.
   a_single_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_DONE |-> rsp_tlast)
      else $error("non-done result without last");

   // A completed sequence carries a command and no text.
   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_DONE |-> rsp_tdata[7:0] == 8'd0 &&
      rsp_tdata[15:8] != 8'd0)
      else $error("done result with bad text or command byte");

   // Parameter words of one sequence come out in index order.
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
      rsp_tvalid && idx == $past(idx) + 3'd1 && rsp_tuser == STATUS_DONE)
      else $error("parameter index did not advance");

   // The last word of a sequence with parameters holds the final index.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (MAX_PARAMS <= 8) && rsp_tvalid && rsp_tlast && rsp_tuser == STATUS_DONE &&
      cnt != 4'd0 |-> {1'b0, idx} + 4'd1 == cnt)
      else $error("last word index does not match parameter count");

endmodule

bind ansi_csi_escape_parser acep_checker #(
   .MAX_PARAMS(MAX_PARAMS),
   .PARAM_BITS(PARAM_BITS)
) u_acep_checker (.*);

FILE: bench/tb_ansi_csi_escape_parser.sv
// Self-checking testbench for ansi_csi_escape_parser: a directed byte script, then random
// terminal traffic, checked word by word against a predictor kept inside this module.
// Depends on acep_pkg and the ansi_csi_escape_parser RTL.
module tb_ansi_csi_escape_parser
   import acep_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PARAM_LIMIT = 8;
   localparam int VALUE_MAX = 65535;
   localparam int ITEM_TARGET = 470;
   localparam int PRESSURE_AT = 150;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT = 600000;

   typedef enum logic [2:0] {
      PS_IDLE, PS_ESC, PS_BRACKET, PS_NUMBER, PS_SEMI, PS_EQUALS
   } parse_step_type;

   typedef enum logic [1:0] {
      FROM_BRACKET, FROM_EQUALS, FROM_SEMI
   } number_origin_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  text_byte;
      logic [7:0]  command_byte;
      logic        private_mode;
      logic [2:0]  param_index;
      logic [15:0] param_value;
      logic [3:0]  param_count;
      logic        last;
   } parse_result_type;

   typedef struct packed {
      logic [7:0] data;
      bit         typed;
      logic [2:0] status;
      logic [7:0] text;
   } script_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // byte_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // text_byte, command_byte, private_mode, param_index, param_value, param_count
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;           // status
   logic        rsp_tlast;

   // Predictor state.
   parse_step_type    seq_state = PS_IDLE;
   number_origin_type num_origin = FROM_BRACKET;
   logic [3:0]        semi_count = '0;
   logic [15:0]       param_vals [0:PARAM_LIMIT-1];
   int unsigned       param_total = 0;
   logic              seq_private = 1'b0;
   logic              digits_live = 1'b0;

   parse_result_type pending_results [$];
   parse_result_type step_results [$];
   logic [7:0]       planned_bytes [$];

   logic [7:0] bracket_finals [0:9] = '{CHAR_UP_H, CHAR_LO_F, CHAR_LO_M, CHAR_LO_S, CHAR_LO_U,
                                        CHAR_UP_K, CHAR_UP_A, CHAR_UP_B, CHAR_UP_C, CHAR_UP_D};
   logic [7:0] number_finals [0:5] = '{CHAR_UP_A, CHAR_UP_B, CHAR_UP_C, CHAR_UP_D,
                                       CHAR_LO_J, CHAR_LO_M};
   logic [7:0] semi_finals [0:2] = '{CHAR_LO_M, CHAR_UP_H, CHAR_LO_F};
   logic [7:0] noise_bytes [0:9] = '{CHAR_ESC, CHAR_BRACKET, CHAR_EQUALS, CHAR_SEMI, CHAR_ZERO,
                                     CHAR_NINE, CHAR_LO_M, CHAR_UP_H, CHAR_LO_H, CHAR_LO_J};

   // Typed rows carry their expected word; the others go through the predictor.
   script_row_type script [0:25] = '{
      '{8'h00,        1'b1, STATUS_TEXT,       8'h00},
      '{8'hFF,        1'b1, STATUS_TEXT,       8'hFF},
      '{CHAR_ESC,     1'b1, STATUS_ABSORBED,   8'h00},
      '{CHAR_BRACKET, 1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_NINE,    1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_NINE,    1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_NINE,    1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_NINE,    1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_NINE,    1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_SEMI,    1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_SEMI,    1'b0, STATUS_ABSORBED,   8'h00},
      '{8'h31,        1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_LO_M,    1'b0, STATUS_DONE,       8'h00},
      '{CHAR_ESC,     1'b1, STATUS_ABSORBED,   8'h00},
      '{CHAR_ESC,     1'b1, STATUS_ABORT_ESC,  8'h00},
      '{CHAR_BRACKET, 1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_LO_M,    1'b0, STATUS_DONE,       8'h00},
      '{CHAR_ESC,     1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_BRACKET, 1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_EQUALS,  1'b0, STATUS_ABSORBED,   8'h00},
      '{8'h37,        1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_LO_L,    1'b0, STATUS_DONE,       8'h00},
      '{CHAR_ESC,     1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_BRACKET, 1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_EQUALS,  1'b0, STATUS_ABSORBED,   8'h00},
      '{CHAR_LO_M,    1'b1, STATUS_ABORT_TEXT, CHAR_LO_M}
   };

   int  mismatches = 0;
   int  cycle_count = 0;
   int  items_sent = 0;
   bit  sender_steady = 1'b0;
   bit  long_hold_due = 1'b0;

   ansi_csi_escape_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic void push_simple(logic [2:0] status, logic [7:0] value);
      logic [7:0] text;
      text = (status == STATUS_TEXT || status == STATUS_ABORT_TEXT) ? value : 8'h00;
      step_results.insert(step_results.size(),
                          '{status, text, 8'h00, 1'b0, 3'd0, 16'd0, 4'd0, 1'b1});
   endfunction

   function automatic void clear_sequence();
      seq_state = PS_IDLE;
      num_origin = FROM_BRACKET;
      semi_count = '0;
      param_total = 0;
      seq_private = 1'b0;
      digits_live = 1'b0;
   endfunction

   // Digits past the eighth stored parameter are parsed but go nowhere.
   function automatic void begin_number(logic [7:0] digit, number_origin_type origin);
      seq_state = PS_NUMBER;
      num_origin = origin;
      if (param_total < PARAM_LIMIT) begin
         param_vals[param_total] = 16'(digit - CHAR_ZERO);
         param_total++;
         digits_live = 1'b1;
      end else begin
         digits_live = 1'b0;
      end
   endfunction

   function automatic void count_semicolon();
      seq_state = PS_SEMI;
      digits_live = 1'b0;
      if (semi_count < 4'd15) semi_count++;
   endfunction

   // Advances the parser state by one byte and leaves the words it causes in step_results.
   function automatic void predict_byte(logic [7:0] value);
      bit          is_digit;
      bit          absorbed;
      bit          completes;
      bit          aborted;
      int unsigned grown;
      int unsigned words;
      is_digit = (value >= CHAR_ZERO && value <= CHAR_NINE);
      absorbed = 1'b0;
      completes = 1'b0;
      step_results.delete();
      case (seq_state)
         PS_ESC: begin
            if (value == CHAR_BRACKET) begin
               seq_state = PS_BRACKET;
               absorbed = 1'b1;
            end
         end
         PS_BRACKET: begin
            if (is_digit) begin
               begin_number(value, FROM_BRACKET);
               absorbed = 1'b1;
            end else if (value == CHAR_EQUALS) begin
               seq_state = PS_EQUALS;
               seq_private = 1'b1;
               absorbed = 1'b1;
            end else begin
               case (value)
                  CHAR_UP_H, CHAR_LO_F, CHAR_LO_M, CHAR_LO_S, CHAR_LO_U, CHAR_UP_K,
                  CHAR_UP_A, CHAR_UP_B, CHAR_UP_C, CHAR_UP_D: completes = 1'b1;
                  default: ;
               endcase
            end
         end
         PS_EQUALS: begin
            if (is_digit) begin
               begin_number(value, FROM_EQUALS);
               absorbed = 1'b1;
            end else if (value == CHAR_LO_H || value == CHAR_LO_L) begin
               completes = 1'b1;
            end
         end
         PS_SEMI: begin
            if (is_digit) begin
               begin_number(value, FROM_SEMI);
               absorbed = 1'b1;
            end else if (value == CHAR_SEMI) begin
               count_semicolon();
               absorbed = 1'b1;
            end else if (value == CHAR_LO_M || value == CHAR_UP_H || value == CHAR_LO_F) begin
               completes = 1'b1;
            end
         end
         PS_NUMBER: begin
            if (is_digit) begin
               if (digits_live) begin
                  grown = param_vals[param_total - 1] * 10 + (value - CHAR_ZERO);
                  param_vals[param_total - 1] = (grown > VALUE_MAX) ? 16'hFFFF : grown[15:0];
               end
               absorbed = 1'b1;
            end else begin
               case (num_origin)
                  FROM_BRACKET: begin
                     if (value == CHAR_SEMI) begin
                        count_semicolon();
                        absorbed = 1'b1;
                     end else begin
                        case (value)
                           CHAR_UP_A, CHAR_UP_B, CHAR_UP_C, CHAR_UP_D,
                           CHAR_LO_J, CHAR_LO_M: completes = 1'b1;
                           default: ;
                        endcase
                     end
                  end
                  FROM_EQUALS: completes = (value == CHAR_LO_H || value == CHAR_LO_L);
                  default: begin
                     // H and f close a number only when exactly one separator came before.
                     if ((semi_count == 4'd1 && (value == CHAR_UP_H || value == CHAR_LO_F)) ||
                         value == CHAR_LO_M) begin
                        completes = 1'b1;
                     end else if (value == CHAR_SEMI) begin
                        count_semicolon();
                        absorbed = 1'b1;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase

      if (absorbed) begin
         push_simple(STATUS_ABSORBED, value);
      end else if (completes) begin
         words = (param_total == 0) ? 1 : param_total;
         for (int k = 0; k < words; k++) begin
            step_results.insert(step_results.size(),
                                '{STATUS_DONE, 8'h00, value, seq_private, 3'(k),
                                  (param_total == 0) ? 16'd0 : param_vals[k],
                                  4'(param_total), (k + 1 == words)});
         end
         clear_sequence();
      end else begin
         // A byte that breaks a sequence is then treated as if the parser were idle.
         aborted = (seq_state != PS_IDLE);
         clear_sequence();
         if (value == CHAR_ESC) begin
            seq_state = PS_ESC;
            push_simple(aborted ? STATUS_ABORT_ESC : STATUS_ABSORBED, value);
         end else begin
            push_simple(aborted ? STATUS_ABORT_TEXT : STATUS_TEXT, value);
         end
      end
   endfunction

   function automatic void plan_number();
      int unsigned digits;
      digits = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
      repeat (digits) begin
         planned_bytes.insert(planned_bytes.size(), CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   // Valid stays high from one word to the next when there is no gap, so it is
   // only ever assigned once per falling edge.
   task automatic send_byte(input logic [7:0] value, input bit typed,
                            input parse_result_type typed_result);
      int unsigned gap;
      gap = sender_steady ? 0 : idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      predict_byte(value);
      if (typed) pending_results.insert(pending_results.size(), typed_result);
      else foreach (step_results[i]) pending_results.insert(pending_results.size(),
                                                            step_results[i]);
      items_sent++;
      if (items_sent == PRESSURE_AT) long_hold_due = 1'b1;
   endtask

   initial begin : sink_pacing
      int unsigned stall;
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            stall = LONG_HOLD_CYCLES;
         end else begin
            stall = idle_gap();
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 40 : 6)) @(negedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      parse_result_type seen;
      parse_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[16],
                  rsp_tdata[19:17], rsp_tdata[35:20], rsp_tdata[39:36], rsp_tlast};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, seen);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, seen.status);
            check_field("text_byte", want.text_byte, seen.text_byte);
            check_field("command_byte", want.command_byte, seen.command_byte);
            check_field("private_mode", want.private_mode, seen.private_mode);
            check_field("param_index", want.param_index, seen.param_index);
            check_field("param_value", want.param_value, seen.param_value);
            check_field("param_count", want.param_count, seen.param_count);
            check_field("last", want.last, seen.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned kind;
      int unsigned fields;
      bit          last_empty;
      logic [7:0]  final_byte;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_byte(script[i].data, script[i].typed,
                   '{script[i].status, script[i].text, 8'h00, 1'b0, 3'd0, 16'd0, 4'd0, 1'b1});
      end

      // Mostly well-formed sequences with random content, some plain text and noise.
      while (items_sent < ITEM_TARGET) begin
         planned_bytes.delete();
         sender_steady = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            repeat ($urandom_range(1, 4)) begin
               planned_bytes.insert(planned_bytes.size(), 8'($urandom_range(0, 255)));
            end
         end else if (kind < 23) begin
            repeat ($urandom_range(1, 3)) begin
               planned_bytes.insert(planned_bytes.size(), noise_bytes[$urandom_range(0, 9)]);
            end
         end else begin
            planned_bytes.insert(planned_bytes.size(), CHAR_ESC);
            planned_bytes.insert(planned_bytes.size(), CHAR_BRACKET);
            case ($urandom_range(0, 3))
               0: final_byte = bracket_finals[$urandom_range(0, 9)];
               1: begin
                  planned_bytes.insert(planned_bytes.size(), CHAR_EQUALS);
                  if ($urandom_range(0, 1) == 1) plan_number();
                  final_byte = ($urandom_range(0, 1) == 1) ? CHAR_LO_H : CHAR_LO_L;
               end
               2: begin
                  plan_number();
                  final_byte = number_finals[$urandom_range(0, 5)];
               end
               default: begin
                  // Occasionally long enough to overflow the store and the separator count.
                  fields = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 18 : 5);
                  plan_number();
                  last_empty = 1'b0;
                  for (int f = 1; f < fields; f++) begin
                     planned_bytes.insert(planned_bytes.size(), CHAR_SEMI);
                     last_empty = ($urandom_range(0, 5) == 0);
                     if (!last_empty) plan_number();
                  end
                  if (fields == 2 || last_empty) final_byte = semi_finals[$urandom_range(0, 2)];
                  else final_byte = CHAR_LO_M;
               end
            endcase
            if ($urandom_range(0, 7) == 0) begin
               planned_bytes.insert(planned_bytes.size(), 8'($urandom_range(0, 255)));
            end
            planned_bytes.insert(planned_bytes.size(), final_byte);
         end
         foreach (planned_bytes[i]) send_byte(planned_bytes[i], 1'b0, '0);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: ansi_csi_escape_parser.f
rtl/acep_pkg.sv
rtl/acep_front.sv
rtl/acep_queue.sv
rtl/acep_back.sv
rtl/ansi_csi_escape_parser.sv
rtl/acep_checker.sv
bench/tb_ansi_csi_escape_parser.sv
